// ===== rtl/core/tbs_pkg.sv =====
// Shared constants, types and helper functions of the triangle tangent basis pipeline.
package tbs_pkg;

   localparam int OUT_BITS = 8;
   localparam int K_W      = OUT_BITS - 1;
   localparam int MX       = (1 << K_W) - 1;
   localparam int QSQ_W    = 2 * OUT_BITS;
   localparam int GM_W     = 14;
   localparam int G2_W     = 2 * GM_W;
   localparam int S_W      = G2_W + 2;
   localparam int Q_W      = QSQ_W + S_W;
   localparam int LIM_W    = QSQ_W + G2_W;
   localparam logic [QSQ_W-1:0] LIM_K = QSQ_W'(4 * MX * MX);
   localparam int TR_W     = 31;
   localparam int GR_W     = GM_W + 1;
   localparam int REQ_W    = 304;
   localparam int RSP_W    = ((4 * OUT_BITS + 7) / 8) * 8;
   localparam logic [5:0] T_TOP = 6'd29;
   localparam logic [5:0] G_TOP = 6'd13;

   typedef struct packed {
      logic             valid;
      logic [2:0][31:0] e_one;
      logic [2:0][31:0] e_two;
      logic [31:0]      uv_one;
      logic [31:0]      uv_two;
      logic [2:0][15:0] n;
   } in_type;

   typedef struct packed {
      logic                  valid;
      logic                  deg;
      logic [2:0][TR_W-1:0]  t;
      logic [2:0][TR_W-1:0]  b;
      logic [2:0][15:0]      n;
   } frame_type;

   typedef struct packed {
      logic                  valid;
      logic                  deg;
      logic [2:0][GR_W-1:0]  g;
      logic [2:0][TR_W-1:0]  b;
      logic [2:0][15:0]      n;
   } ortho_type;

   typedef struct packed {
      logic                  valid;
      logic                  deg;
      logic                  hand_neg;
      logic [2:0][K_W-1:0]   k;
      logic [2:0]            neg;
      logic [S_W-1:0]        s;
      logic [2:0][LIM_W-1:0] lim;
   } qstage_type;

   // Position of the highest set bit; zero for a zero word.
   function automatic logic [5:0] lead_pos(input logic [63:0] v);
      logic [5:0] p;
      p = 6'd0;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) p = 6'(i);
      end
      return p;
   endfunction

   // Scales a magnitude so that its leading one lands on bit position top.
   function automatic logic [63:0] norm_shift(input logic [63:0] mag, input logic [5:0] pos,
                                              input logic [5:0] top);
      logic [63:0] r;
      if (pos >= top) r = mag >> (pos - top);
      else r = mag << (top - pos);
      return r;
   endfunction

endpackage

// ===== rtl/core/triangle_tangent_basis_snorm8_unit.sv =====
// Top level of the triangle tangent basis unit with snorm8 output packing.
//
// Usage: one triangle corner enters per transfer on the req_ channel; it carries
// both edge vectors, both packed UV deltas and the vertex normal. For each transfer
// exactly one result leaves on the rsp_ channel: the orthogonalized, normalized
// tangent as three snorm8 components, the handedness as +127 or -127, and a
// degenerate flag on rsp_tuser that zeroes all components when the UV determinant
// or the orthogonalized tangent vanishes.
// From an accepted request to the result on the output register the pipeline has
// 5 stages of edge combination and renormalization, 7 of Gram-Schmidt
// and renormalization, 3 of handedness, 14 of magnitude search (two per result bit)
// and the output register. Throughput is one transfer per cycle while the output
// is not stalled; the pipeline is fully staged with a valid bit in every stage.
// The whole pipeline advances on one enable: when rsp_tvalid is high and
// rsp_tready low, every stage holds and req_tready drops, so nothing is lost or
// repeated. Synchronous reset clears all valid bits; no result is pending after it.
module triangle_tangent_basis_snorm8_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // From bit 0: edge_one_x, edge_one_y, edge_one_z, edge_two_x, edge_two_y,
   // edge_two_z, uv_delta_one, uv_delta_two, normal_x, normal_y, normal_z.
   input  logic [tbs_pkg::REQ_W-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // From bit 0: tangent_x, tangent_y, tangent_z, tangent_w.
   output logic [tbs_pkg::RSP_W-1:0] rsp_tdata,
   // Bit 0: degenerate.
   output logic [0:0]                rsp_tuser
);
   import tbs_pkg::*;

   logic       en;
   in_type     in_s;
   frame_type  frame_s;
   ortho_type  ortho_s;
   qstage_type quant_s;

   logic                     rsp_valid_ff;
   logic [3:0][OUT_BITS-1:0] rsp_tan_ff;
   logic                     rsp_deg_ff;

   // The pipeline moves whenever the output register is empty or being drained.
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   always_comb begin
      in_s.valid = req_tvalid;
      for (int i = 0; i < 3; i++) begin
         in_s.e_one[i] = req_tdata[32*i +: 32];
         in_s.e_two[i] = req_tdata[96 + 32*i +: 32];
         in_s.n[i]     = req_tdata[256 + 16*i +: 16];
      end
      in_s.uv_one = req_tdata[223:192];
      in_s.uv_two = req_tdata[255:224];
   end

   tbs_frame u_frame (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .in_i  (in_s),
      .out_o (frame_s)
   );

   tbs_ortho u_ortho (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .in_i  (frame_s),
      .out_o (ortho_s)
   );

   tbs_quant u_quant (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .in_i  (ortho_s),
      .out_o (quant_s)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= quant_s.valid;
      end
   end

   // Apply the signs, the handedness and the degenerate override.
   always_ff @(posedge clock) begin
      if (en) begin
         rsp_deg_ff <= quant_s.deg;
         for (int i = 0; i < 3; i++) begin
            if (quant_s.deg) begin
               rsp_tan_ff[i] <= '0;
            end else if (quant_s.neg[i]) begin
               rsp_tan_ff[i] <= -{1'b0, quant_s.k[i]};
            end else begin
               rsp_tan_ff[i] <= {1'b0, quant_s.k[i]};
            end
         end
         if (quant_s.deg) begin
            rsp_tan_ff[3] <= '0;
         end else if (quant_s.hand_neg) begin
            rsp_tan_ff[3] <= -OUT_BITS'(MX);
         end else begin
            rsp_tan_ff[3] <= OUT_BITS'(MX);
         end
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = RSP_W'(rsp_tan_ff);
   assign rsp_tuser[0] = rsp_deg_ff;

endmodule

// ===== rtl/core/tbs_frame.sv =====
// Edge combination by UV deltas, determinant sign and renormalization of tangent and bitangent.
module tbs_frame (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  tbs_pkg::in_type    in_i,
   output tbs_pkg::frame_type out_o
);
   import tbs_pkg::*;

   logic signed [15:0] u1, v1, u2, v2;
   assign u1 = $signed(in_i.uv_one[15:0]);
   assign v1 = $signed(in_i.uv_one[31:16]);
   assign u2 = $signed(in_i.uv_two[15:0]);
   assign v2 = $signed(in_i.uv_two[31:16]);

   // Stage 1: products.
   logic               s1_valid_ff;
   logic signed [31:0] dp_ff [2];
   logic signed [47:0] tp_ff [2][3];
   logic signed [47:0] bp_ff [2][3];
   logic [2:0][15:0]   n1_ff;

   // Stage 2: differences.
   logic               s2_valid_ff;
   logic signed [32:0] det_ff;
   logic signed [48:0] t2_ff [3];
   logic signed [48:0] b2_ff [3];
   logic [2:0][15:0]   n2_ff;

   // Stage 3: magnitudes and sign.
   logic               s3_valid_ff, s3_dz_ff;
   logic [47:0]        tm3_ff [3], bm3_ff [3];
   logic [2:0]         ts3_ff, bs3_ff;
   logic [47:0]        tor3_ff, bor3_ff;
   logic [2:0][15:0]   n3_ff;

   // Stage 4: leading-one positions.
   logic               s4_valid_ff, s4_deg_ff;
   logic [47:0]        tm4_ff [3], bm4_ff [3];
   logic [2:0]         ts4_ff, bs4_ff;
   logic [5:0]         tp4_ff, bp4_ff;
   logic [2:0][15:0]   n4_ff;

   // Stage 5: scaled vectors.
   frame_type          out_ff;

   logic [47:0]        tor_in, bor_in;
   always_comb begin
      tor_in = 48'd0;
      bor_in = 48'd0;
      for (int i = 0; i < 3; i++) begin
         tor_in = tor_in | (t2_ff[i][48] ? 48'(-t2_ff[i]) : 48'(t2_ff[i]));
         bor_in = bor_in | (b2_ff[i][48] ? 48'(-b2_ff[i]) : 48'(b2_ff[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         out_ff.valid <= 1'b0;
      end else if (en) begin
         s1_valid_ff  <= in_i.valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         out_ff.valid <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dp_ff[0] <= u1 * v2;
         dp_ff[1] <= v1 * u2;
         n1_ff    <= in_i.n;
         for (int i = 0; i < 3; i++) begin
            tp_ff[0][i] <= $signed(in_i.e_one[i]) * v2;
            tp_ff[1][i] <= $signed(in_i.e_two[i]) * v1;
            bp_ff[0][i] <= $signed(in_i.e_two[i]) * u1;
            bp_ff[1][i] <= $signed(in_i.e_one[i]) * u2;
         end

         det_ff <= 33'(dp_ff[0]) - 33'(dp_ff[1]);
         n2_ff  <= n1_ff;
         for (int i = 0; i < 3; i++) begin
            t2_ff[i] <= 49'(tp_ff[0][i]) - 49'(tp_ff[1][i]);
            b2_ff[i] <= 49'(bp_ff[0][i]) - 49'(bp_ff[1][i]);
         end

         // A negative determinant flips both vectors, which only flips the signs.
         s3_dz_ff <= (det_ff == 33'sd0);
         n3_ff    <= n2_ff;
         tor3_ff  <= tor_in;
         bor3_ff  <= bor_in;
         for (int i = 0; i < 3; i++) begin
            tm3_ff[i] <= t2_ff[i][48] ? 48'(-t2_ff[i]) : 48'(t2_ff[i]);
            bm3_ff[i] <= b2_ff[i][48] ? 48'(-b2_ff[i]) : 48'(b2_ff[i]);
            ts3_ff[i] <= t2_ff[i][48] ^ det_ff[32];
            bs3_ff[i] <= b2_ff[i][48] ^ det_ff[32];
         end

         s4_deg_ff <= s3_dz_ff || (tor3_ff == 48'd0);
         tp4_ff    <= lead_pos({16'd0, tor3_ff});
         bp4_ff    <= lead_pos({16'd0, bor3_ff});
         tm4_ff    <= tm3_ff;
         bm4_ff    <= bm3_ff;
         ts4_ff    <= ts3_ff;
         bs4_ff    <= bs3_ff;
         n4_ff     <= n3_ff;

         out_ff.deg <= s4_deg_ff;
         out_ff.n   <= n4_ff;
         for (int i = 0; i < 3; i++) begin
            out_ff.t[i] <= ts4_ff[i]
               ? TR_W'(-{1'b0, norm_shift({16'd0, tm4_ff[i]}, tp4_ff, T_TOP)})
               : TR_W'({1'b0, norm_shift({16'd0, tm4_ff[i]}, tp4_ff, T_TOP)});
            out_ff.b[i] <= bs4_ff[i]
               ? TR_W'(-{1'b0, norm_shift({16'd0, bm4_ff[i]}, bp4_ff, T_TOP)})
               : TR_W'({1'b0, norm_shift({16'd0, bm4_ff[i]}, bp4_ff, T_TOP)});
         end
      end
   end

   assign out_o = out_ff;

endmodule

// ===== rtl/core/tbs_ortho.sv =====
// Gram-Schmidt removal of the normal component and renormalization of the tangent.
module tbs_ortho (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  tbs_pkg::frame_type in_i,
   output tbs_pkg::ortho_type out_o
);
   import tbs_pkg::*;

   frame_type          f1_ff, f2_ff, f3_ff, f4_ff, f5_ff, f6_ff;
   logic signed [46:0] tn_ff [3];
   logic signed [48:0] dot_ff;
   logic signed [63:0] nd_ff [3];
   logic signed [63:0] g4_ff [3];
   logic [62:0]        gm5_ff [3], gm6_ff [3];
   logic [2:0]         gs5_ff, gs6_ff;
   logic [62:0]        gor5_ff;
   logic [5:0]         gp6_ff;
   logic               gz6_ff;
   ortho_type          out_ff;

   logic signed [64:0] nd_in [3];
   logic signed [63:0] tsh   [3];
   logic [62:0]        gor_in;
   always_comb begin
      gor_in = 63'd0;
      for (int i = 0; i < 3; i++) begin
         nd_in[i] = $signed(f2_ff.n[i]) * dot_ff;
         tsh[i]   = $signed({{5{f3_ff.t[i][TR_W-1]}}, f3_ff.t[i], 28'd0});
         gor_in   = gor_in | (g4_ff[i][63] ? 63'(-g4_ff[i]) : 63'(g4_ff[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_ff.valid  <= 1'b0;
         f2_ff.valid  <= 1'b0;
         f3_ff.valid  <= 1'b0;
         f4_ff.valid  <= 1'b0;
         f5_ff.valid  <= 1'b0;
         f6_ff.valid  <= 1'b0;
         out_ff.valid <= 1'b0;
      end else if (en) begin
         f1_ff.valid  <= in_i.valid;
         f2_ff.valid  <= f1_ff.valid;
         f3_ff.valid  <= f2_ff.valid;
         f4_ff.valid  <= f3_ff.valid;
         f5_ff.valid  <= f4_ff.valid;
         f6_ff.valid  <= f5_ff.valid;
         out_ff.valid <= f6_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         {f1_ff.deg, f1_ff.t, f1_ff.b, f1_ff.n} <= {in_i.deg, in_i.t, in_i.b, in_i.n};
         {f2_ff.deg, f2_ff.t, f2_ff.b, f2_ff.n} <= {f1_ff.deg, f1_ff.t, f1_ff.b, f1_ff.n};
         {f3_ff.deg, f3_ff.t, f3_ff.b, f3_ff.n} <= {f2_ff.deg, f2_ff.t, f2_ff.b, f2_ff.n};
         {f4_ff.deg, f4_ff.t, f4_ff.b, f4_ff.n} <= {f3_ff.deg, f3_ff.t, f3_ff.b, f3_ff.n};
         {f5_ff.deg, f5_ff.t, f5_ff.b, f5_ff.n} <= {f4_ff.deg, f4_ff.t, f4_ff.b, f4_ff.n};
         {f6_ff.deg, f6_ff.t, f6_ff.b, f6_ff.n} <= {f5_ff.deg, f5_ff.t, f5_ff.b, f5_ff.n};

         for (int i = 0; i < 3; i++) begin
            tn_ff[i] <= $signed(in_i.t[i]) * $signed(in_i.n[i]);
         end
         dot_ff <= 49'(tn_ff[0]) + 49'(tn_ff[1]) + 49'(tn_ff[2]);
         for (int i = 0; i < 3; i++) begin
            nd_ff[i]  <= nd_in[i][63:0];
            g4_ff[i]  <= tsh[i] - nd_ff[i];
            gm5_ff[i] <= g4_ff[i][63] ? 63'(-g4_ff[i]) : 63'(g4_ff[i]);
            gs5_ff[i] <= g4_ff[i][63];
         end
         gor5_ff <= gor_in;

         gp6_ff <= lead_pos({1'b0, gor5_ff});
         gz6_ff <= (gor5_ff == 63'd0);
         gm6_ff <= gm5_ff;
         gs6_ff <= gs5_ff;

         out_ff.deg <= f6_ff.deg || gz6_ff;
         out_ff.b   <= f6_ff.b;
         out_ff.n   <= f6_ff.n;
         for (int i = 0; i < 3; i++) begin
            out_ff.g[i] <= gs6_ff[i]
               ? GR_W'(-{1'b0, norm_shift({1'b0, gm6_ff[i]}, gp6_ff, G_TOP)})
               : GR_W'({1'b0, norm_shift({1'b0, gm6_ff[i]}, gp6_ff, G_TOP)});
         end
      end
   end

   assign out_o = out_ff;

endmodule

// ===== rtl/core/tbs_quant.sv =====
// Handedness sign and bit-by-bit search of the rounded snorm magnitudes.
module tbs_quant (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  tbs_pkg::ortho_type  in_i,
   output tbs_pkg::qstage_type out_o
);
   import tbs_pkg::*;

   // Head stage 1: squares and cross product of normal and tangent.
   logic                h1_valid_ff, h1_deg_ff;
   logic [G2_W-1:0]     g2_ff [3];
   logic signed [31:0]  cr_ff [3];
   logic [2:0]          neg1_ff;
   logic [2:0][TR_W-1:0] b1_ff;

   // Head stage 2: sum of squares, limits and handedness products.
   logic                h2_valid_ff, h2_deg_ff;
   logic [S_W-1:0]      s2_ff;
   logic [LIM_W-1:0]    lim2_ff [3];
   logic signed [62:0]  hp_ff [3];
   logic [2:0]          neg2_ff;

   qstage_type          head_ff;
   qstage_type          qa_ff [K_W];
   qstage_type          qb_ff [K_W];
   logic [QSQ_W-1:0]    sq_ff [K_W][3];

   logic [GM_W-1:0]     gm [3];
   logic signed [31:0]  cr_in [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         gm[i] = in_i.g[i][GR_W-1] ? GM_W'(-$signed(in_i.g[i])) : in_i.g[i][GM_W-1:0];
      end
      cr_in[0] = $signed(in_i.n[1]) * $signed(in_i.g[2]) - $signed(in_i.n[2]) * $signed(in_i.g[1]);
      cr_in[1] = $signed(in_i.n[2]) * $signed(in_i.g[0]) - $signed(in_i.n[0]) * $signed(in_i.g[2]);
      cr_in[2] = $signed(in_i.n[0]) * $signed(in_i.g[1]) - $signed(in_i.n[1]) * $signed(in_i.g[0]);
   end

   logic signed [64:0] hand_in;
   assign hand_in = 65'(hp_ff[0]) + 65'(hp_ff[1]) + 65'(hp_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         h1_valid_ff   <= 1'b0;
         h2_valid_ff   <= 1'b0;
         head_ff.valid <= 1'b0;
      end else if (en) begin
         h1_valid_ff   <= in_i.valid;
         h2_valid_ff   <= h1_valid_ff;
         head_ff.valid <= h2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         h1_deg_ff <= in_i.deg;
         b1_ff     <= in_i.b;
         for (int i = 0; i < 3; i++) begin
            g2_ff[i]   <= gm[i] * gm[i];
            cr_ff[i]   <= cr_in[i];
            neg1_ff[i] <= in_i.g[i][GR_W-1];
         end

         h2_deg_ff <= h1_deg_ff;
         neg2_ff   <= neg1_ff;
         s2_ff     <= S_W'(g2_ff[0]) + S_W'(g2_ff[1]) + S_W'(g2_ff[2]);
         for (int i = 0; i < 3; i++) begin
            lim2_ff[i] <= LIM_W'(g2_ff[i]) * LIM_W'(LIM_K);
            hp_ff[i]   <= cr_ff[i] * $signed(b1_ff[i]);
         end

         head_ff.deg      <= h2_deg_ff;
         head_ff.hand_neg <= hand_in[64];
         head_ff.neg      <= neg2_ff;
         head_ff.s        <= s2_ff;
         for (int i = 0; i < 3; i++) begin
            head_ff.k[i]   <= '0;
            head_ff.lim[i] <= lim2_ff[i];
         end
      end
   end

   // Each bit takes two stages: square of the odd candidate, then the scaled compare.
   for (genvar j = 0; j < K_W; j++) begin : g_bit
      localparam int BIT = K_W - 1 - j;
      qstage_type       src;
      logic [K_W-1:0]   cand_a [3];
      logic [K_W-1:0]   cand_b [3];
      logic [OUT_BITS-1:0] odd [3];
      logic [Q_W-1:0]   prod [3];

      if (j == 0) begin : g_first
         assign src = head_ff;
      end else begin : g_next
         assign src = qb_ff[j-1];
      end

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            cand_a[i] = src.k[i] | (K_W'(1) << BIT);
            odd[i]    = {cand_a[i], 1'b0} - OUT_BITS'(1);
            cand_b[i] = qa_ff[j].k[i] | (K_W'(1) << BIT);
            prod[i]   = Q_W'(sq_ff[j][i]) * Q_W'(qa_ff[j].s);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            qa_ff[j].valid <= 1'b0;
            qb_ff[j].valid <= 1'b0;
         end else if (en) begin
            qa_ff[j].valid <= src.valid;
            qb_ff[j].valid <= qa_ff[j].valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            {qa_ff[j].deg, qa_ff[j].hand_neg, qa_ff[j].k, qa_ff[j].neg, qa_ff[j].s,
             qa_ff[j].lim} <= {src.deg, src.hand_neg, src.k, src.neg, src.s, src.lim};
            {qb_ff[j].deg, qb_ff[j].hand_neg, qb_ff[j].neg, qb_ff[j].s, qb_ff[j].lim} <=
               {qa_ff[j].deg, qa_ff[j].hand_neg, qa_ff[j].neg, qa_ff[j].s, qa_ff[j].lim};
            for (int i = 0; i < 3; i++) begin
               sq_ff[j][i]    <= QSQ_W'(odd[i]) * QSQ_W'(odd[i]);
               qb_ff[j].k[i]  <= (prod[i] <= Q_W'(qa_ff[j].lim[i])) ? cand_b[i] : qa_ff[j].k[i];
            end
         end
      end
   end

   assign out_o = qb_ff[K_W-1];

endmodule
